// File: rtl/markov_transition_sampler_defines.svh
// assertion helpers for the transition sampler
`ifndef MARKOV_TRANSITION_SAMPLER_DEFINES_SVH
`define MARKOV_TRANSITION_SAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
`define MTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("markov_transition_sampler: check failed");
`define MTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("markov_transition_sampler: check failed");
`else
`define MTS_ASSERT_NOW(lbl, ante, cons)
`define MTS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/mts_pkg.sv
package mts_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam int LABEL_W     = 16;
  localparam int FRAC_W      = 16;
  localparam int PROB_W      = FRAC_W + 1;
  localparam int IDX_W       = 4;
  localparam int REG_W       = 5;
  localparam int CFG_INDEX_W = 4;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int S_TDATA_W   = 96;
  localparam int M_TDATA_W   = 16;

  localparam logic [REG_W-1:0]       COUNT_RESET     = 5'd16;
  localparam logic [LABEL_W-1:0]     NOT_FOUND_CLASS = 16'hFFFF;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_USE = 4'd1;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE    = 2'd0,
    OP_ROW_LABEL = 2'd1,
    OP_COL_LABEL = 2'd2,
    OP_PROB      = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_UNCHANGED = 2'd0,
    ST_SAMPLED   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROWS  = 5'b00010,
    S_COLS  = 5'b00100,
    S_LABEL = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [REG_W-1:0] rows_in_use;
    logic [REG_W-1:0] cols_in_use;
  } cfg_t;

  typedef struct packed {
    op_t                 operation;
    logic [LABEL_W-1:0]  first_cell;
    logic [LABEL_W-1:0]  second_cell;
    logic [FRAC_W-1:0]   random_fraction;
    logic [IDX_W-1:0]    entry_row;
    logic [IDX_W-1:0]    entry_col;
    logic [LABEL_W-1:0]  label_value;
    logic [PROB_W-1:0]   probability;
  } req_t;

  typedef struct packed {
    logic [LABEL_W-1:0] new_class;
    status_t            status;
  } res_t;

endpackage

// File: rtl/mts_ram.sv
module mts_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mts_seq.sv
module mts_seq #(
  parameter int MAX_ROWS = mts_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mts_pkg::MAX_COLS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  mts_pkg::cfg_t cfg,
  input  mts_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          res_valid,
  input  logic          res_take,
  output mts_pkg::res_t res
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int AW  = $clog2(MAX_ROWS * MAX_COLS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int SW  = mts_pkg::PROB_W + $clog2(MAX_COLS);

  mts_pkg::state_t state;

  logic [RCW-1:0] nrows;
  logic [CCW-1:0] ncols;

  logic [mts_pkg::LABEL_W-1:0] second_cell;
  logic [mts_pkg::FRAC_W-1:0]  rnd;

  logic [RCW-1:0] rd_idx;
  logic           row_vld;
  logic [RW-1:0]  row_idx;
  logic [AW-1:0]  base;
  logic [CCW-1:0] col_idx;
  logic           col_vld;
  logic [CW-1:0]  col_cur;
  logic [SW-1:0]  sum;
  logic [CW-1:0]  pick;

  logic [mts_pkg::LABEL_W-1:0] res_class;
  mts_pkg::status_t            res_status;
  logic                        from_col;

  logic                        accept;
  logic                        both_pos;
  logic                        row_issue;
  logic                        row_hit;
  logic                        col_issue;
  logic                        col_hit;
  logic [SW-1:0]               sum_new;
  logic [mts_pkg::LABEL_W-1:0] row_rdata;
  logic [mts_pkg::LABEL_W-1:0] col_rdata;
  logic [mts_pkg::PROB_W-1:0]  prob_rdata;

  logic          row_we;
  logic          col_we;
  logic          prob_we;
  logic [AW-1:0] prob_waddr;

  // register values above the table size act as the table size
  always_comb begin
    if (int'(cfg.rows_in_use) > MAX_ROWS) begin
      nrows = RCW'(MAX_ROWS);
    end else begin
      nrows = RCW'(cfg.rows_in_use);
    end
    if (int'(cfg.cols_in_use) > MAX_COLS) begin
      ncols = CCW'(MAX_COLS);
    end else begin
      ncols = CCW'(cfg.cols_in_use);
    end
  end

  assign req_ready = (state == mts_pkg::S_IDLE);
  assign accept    = req_valid && req_ready;
  assign both_pos  = ($signed(req.first_cell) > 0) && ($signed(req.second_cell) > 0);

  assign row_issue = (rd_idx < nrows);
  assign row_hit   = row_vld && (row_rdata == second_cell);
  assign col_issue = (col_idx < ncols);
  assign sum_new   = sum + SW'(prob_rdata);
  assign col_hit   = col_vld && (SW'(rnd) <= sum_new);

  // table writes happen only while idle, so no read can overlap them
  assign row_we  = accept && (req.operation == mts_pkg::OP_ROW_LABEL)
                   && (int'(req.entry_row) < MAX_ROWS);
  assign col_we  = accept && (req.operation == mts_pkg::OP_COL_LABEL)
                   && (int'(req.entry_col) < MAX_COLS);
  assign prob_we = accept && (req.operation == mts_pkg::OP_PROB)
                   && (int'(req.entry_row) < MAX_ROWS) && (int'(req.entry_col) < MAX_COLS);
  assign prob_waddr = AW'(int'(req.entry_row) * MAX_COLS + int'(req.entry_col));

  mts_ram #(.DEPTH(MAX_ROWS), .WIDTH(mts_pkg::LABEL_W)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (RW'(req.entry_row)),
    .wdata (req.label_value),
    .raddr (rd_idx[RW-1:0]),
    .rdata (row_rdata)
  );

  mts_ram #(.DEPTH(MAX_COLS), .WIDTH(mts_pkg::LABEL_W)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (CW'(req.entry_col)),
    .wdata (req.label_value),
    .raddr (pick),
    .rdata (col_rdata)
  );

  mts_ram #(.DEPTH(MAX_ROWS * MAX_COLS), .WIDTH(mts_pkg::PROB_W)) u_prob_ram (
    .clk   (clk),
    .we    (prob_we),
    .waddr (prob_waddr),
    .wdata (req.probability),
    .raddr (base + AW'(col_idx)),
    .rdata (prob_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mts_pkg::S_IDLE;
      row_vld <= 1'b0;
      col_vld <= 1'b0;
    end else begin
      case (state)
        mts_pkg::S_IDLE: begin
          if (accept && (req.operation == mts_pkg::OP_SAMPLE)) begin
            second_cell <= req.second_cell;
            rnd         <= req.random_fraction;
            rd_idx      <= '0;
            row_vld     <= 1'b0;
            from_col    <= 1'b0;
            if (both_pos) begin
              res_class  <= req.first_cell;
              res_status <= mts_pkg::ST_UNCHANGED;
              state      <= mts_pkg::S_DONE;
            end else if (nrows == '0) begin
              res_class  <= mts_pkg::NOT_FOUND_CLASS;
              res_status <= mts_pkg::ST_NOT_FOUND;
              state      <= mts_pkg::S_DONE;
            end else begin
              state <= mts_pkg::S_ROWS;
            end
          end
        end
        mts_pkg::S_ROWS: begin
          // one label read per cycle, each compared once its registered read data returns
          if (row_issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          row_vld <= row_issue;
          row_idx <= rd_idx[RW-1:0];
          if (row_hit) begin
            base    <= AW'(row_idx) * AW'(MAX_COLS);
            col_idx <= '0;
            col_vld <= 1'b0;
            sum     <= '0;
            state   <= mts_pkg::S_COLS;
          end else if (!row_issue) begin
            res_class  <= mts_pkg::NOT_FOUND_CLASS;
            res_status <= mts_pkg::ST_NOT_FOUND;
            state      <= mts_pkg::S_DONE;
          end
        end
        mts_pkg::S_COLS: begin
          // running sum over the row, first column reaching rnd wins, column 0 if none does
          if (col_issue) begin
            col_idx <= col_idx + 1'b1;
          end
          col_vld <= col_issue;
          col_cur <= col_idx[CW-1:0];
          if (col_vld) begin
            sum <= sum_new;
          end
          if (col_hit) begin
            pick  <= col_cur;
            state <= mts_pkg::S_LABEL;
          end else if (!col_issue) begin
            pick  <= '0;
            state <= mts_pkg::S_LABEL;
          end
        end
        mts_pkg::S_LABEL: begin
          // column label read in flight
          res_status <= mts_pkg::ST_SAMPLED;
          from_col   <= 1'b1;
          state      <= mts_pkg::S_DONE;
        end
        mts_pkg::S_DONE: begin
          if (res_take) begin
            state <= mts_pkg::S_IDLE;
          end
        end
        default: begin
          state <= mts_pkg::S_IDLE;
        end
      endcase
    end
  end

  // column label address holds during done, so the read data stays put
  assign res_valid     = (state == mts_pkg::S_DONE);
  assign res.new_class = from_col ? col_rdata : res_class;
  assign res.status    = res_status;

endmodule

// File: rtl/markov_transition_sampler.sv
// Markov transition sampler: holds a transition table (row class labels,
// column class labels, a 17-bit probability per row and column with 65536
// as one) loaded through write requests on the input stream, and answers
// sample requests with one result each by inverse-cdf lookup; write requests
// leave the block ready for the next request and give no result. A sample
// whose two cells are both positive returns the first cell; otherwise the
// row label memory is read one entry per cycle until the second cell
// matches, and a miss returns -1 after all rows in use are checked, or
// without a search when no row is in use; on a match the probability memory
// is read one column per cycle into a running sum until it reaches the
// random fraction, column 0 being taken when none reaches it, and one more
// read of the column label memory gives the class. Each memory has a single
// read port. One request is worked on at a time; a finished result waits in
// the output register while the next request is taken.
`include "markov_transition_sampler_defines.svh"

module markov_transition_sampler #(
  parameter int MAX_ROWS = mts_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mts_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mts_pkg::REG_W-1:0]       cfg_data,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // first_cell, second_cell, random_fraction, entry_row, entry_col,
  // label_value, probability, zero fill
  input  logic [mts_pkg::S_TDATA_W-1:0]   s_tdata,
  // operation
  input  logic [mts_pkg::OP_W-1:0]        s_tuser,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // new_class
  output logic [mts_pkg::M_TDATA_W-1:0]   m_tdata,
  // status
  output logic [mts_pkg::STATUS_W-1:0]    m_tuser
);

  logic [mts_pkg::REG_W-1:0] rows_in_use;
  logic [mts_pkg::REG_W-1:0] cols_in_use;

  mts_pkg::cfg_t cfg;
  mts_pkg::req_t req;
  mts_pkg::res_t res;
  logic          res_valid;
  logic          res_take;

  // config registers, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= mts_pkg::COUNT_RESET;
      cols_in_use <= mts_pkg::COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mts_pkg::REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        mts_pkg::REG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg.rows_in_use = rows_in_use;
  assign cfg.cols_in_use = cols_in_use;

  // unpack the request word, lowest field first
  assign req.operation       = mts_pkg::op_t'(s_tuser);
  assign req.first_cell      = s_tdata[15:0];
  assign req.second_cell     = s_tdata[31:16];
  assign req.random_fraction = s_tdata[47:32];
  assign req.entry_row       = s_tdata[51:48];
  assign req.entry_col       = s_tdata[55:52];
  assign req.label_value     = s_tdata[71:56];
  assign req.probability     = s_tdata[88:72];

  mts_seq #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output register decouples the sequencer from the downstream side
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= res.new_class;
      m_tuser <= res.status;
    end
  end

  // a write request leaves the block idle for the next request
  `MTS_ASSERT_NEXT(a_write_stays_ready, s_tvalid && s_tready && (s_tuser != mts_pkg::OP_SAMPLE), s_tready)
  // a sample request occupies the sequencer
  `MTS_ASSERT_NEXT(a_sample_goes_busy, s_tvalid && s_tready && (s_tuser == mts_pkg::OP_SAMPLE), !s_tready)
  // a handed-over result shows up on the output
  `MTS_ASSERT_NEXT(a_take_fills_output, res_take, m_tvalid)
  // a missed row always reports class -1
  `MTS_ASSERT_NOW(a_not_found_class, m_tvalid && (m_tuser == mts_pkg::ST_NOT_FOUND), m_tdata == mts_pkg::NOT_FOUND_CLASS)

endmodule

// File: tb/markov_transition_sampler_tb.sv
`timescale 1ns / 100ps

module markov_transition_sampler_tb;
  import mts_pkg::*;

  localparam int IDLE_PERCENT   = 35;
  localparam int PHASES         = 9;
  localparam int PHASE_REQUESTS = 190;
  // longest sample is a full row search plus a full column walk
  localparam int DRAIN_CYCLES   = 2 * (MAX_ROWS_DEF + MAX_COLS_DEF + 6);
  localparam int WATCHDOG_LIMIT = 5000;

  // transition table shadow, sample predictor and pending sample results
  class transition_tracker;
    logic [LABEL_W-1:0] row_label [MAX_ROWS_DEF];
    logic [LABEL_W-1:0] col_label [MAX_COLS_DEF];
    logic [PROB_W-1:0]  chance [MAX_ROWS_DEF][MAX_COLS_DEF];
    logic [REG_W-1:0]   rows_in_use = COUNT_RESET;
    logic [REG_W-1:0]   cols_in_use = COUNT_RESET;
    res_t               pending_samples[$];
    int                 mismatches;
    int                 table_writes;
    int                 outcome_count[3];

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx == REG_ROWS_IN_USE) rows_in_use = val;
      else if (idx == REG_COLS_IN_USE) cols_in_use = val;
    endfunction

    function res_t predict_sample(req_t r);
      logic                  first_pos, second_pos, found, reached;
      int                    rows, cols, hit, pick;
      logic [PROB_W+IDX_W:0] running;
      res_t                  res;
      first_pos  = (r.first_cell != '0) && !r.first_cell[LABEL_W-1];
      second_pos = (r.second_cell != '0) && !r.second_cell[LABEL_W-1];
      if (first_pos && second_pos) begin
        res.new_class = r.first_cell;
        res.status    = ST_UNCHANGED;
        return res;
      end
      // register values past the table size act as the table size
      rows  = (rows_in_use > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_in_use);
      cols  = (cols_in_use > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_in_use);
      found = 1'b0;
      hit   = 0;
      for (int i = 0; i < rows; i++) begin
        if (!found && row_label[i] == r.second_cell) begin
          found = 1'b1;
          hit   = i;
        end
      end
      if (!found) begin
        res.new_class = NOT_FOUND_CLASS;
        res.status    = ST_NOT_FOUND;
        return res;
      end
      // inverse cdf walk; column 0 when the running sum never reaches the fraction
      running = '0;
      reached = 1'b0;
      pick    = 0;
      for (int c = 0; c < cols; c++) begin
        if (!reached) begin
          running += chance[hit][c];
          if (r.random_fraction <= running) begin
            reached = 1'b1;
            pick    = c;
          end
        end
      end
      res.new_class = col_label[pick];
      res.status    = ST_SAMPLED;
      return res;
    endfunction

    function void note_request(req_t r);
      res_t res;
      case (r.operation)
        OP_ROW_LABEL: row_label[r.entry_row] = r.label_value;
        OP_COL_LABEL: col_label[r.entry_col] = r.label_value;
        OP_PROB:      chance[r.entry_row][r.entry_col] = r.probability;
        default: begin
          res = predict_sample(r);
          outcome_count[res.status]++;
          pending_samples.push_back(res);
        end
      endcase
      if (r.operation != OP_SAMPLE) table_writes++;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] cls, logic [STATUS_W-1:0] st);
      res_t want;
      if (pending_samples.size() == 0) begin
        flag($sformatf("unexpected result: class %0d status %0d", $signed(cls), st));
        return;
      end
      want = pending_samples.pop_front();
      if (want.new_class !== cls)
        flag($sformatf("new_class mismatch: expected %0d got %0d",
                       $signed(want.new_class), $signed(cls)));
      if (want.status !== st)
        flag($sformatf("status mismatch: expected %0d got %0d", want.status, st));
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]       cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic [OP_W-1:0]        s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0]    m_tuser;

  logic              steady = 1'b0;
  int                quiet_cycles = 0;
  transition_tracker tracker = new();

  markov_transition_sampler i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side backpressure
  always @(posedge clk) begin
    m_tready <= !rst && (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // accepted traffic feeds the tracker: register writes, requests, then results
  always @(posedge clk) begin
    req_t seen;
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.set_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        seen.operation       = op_t'(s_tuser);
        seen.first_cell      = s_tdata[15:0];
        seen.second_cell     = s_tdata[31:16];
        seen.random_fraction = s_tdata[47:32];
        seen.entry_row       = s_tdata[51:48];
        seen.entry_col       = s_tdata[55:52];
        seen.label_value     = s_tdata[71:56];
        seen.probability     = s_tdata[88:72];
        tracker.note_request(seen);
      end
      if (m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic req_t make_item(op_t op, logic [LABEL_W-1:0] first_cell,
                                     logic [LABEL_W-1:0] second_cell,
                                     logic [FRAC_W-1:0] fraction,
                                     logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                     logic [LABEL_W-1:0] label, logic [PROB_W-1:0] prob);
    req_t r;
    r.operation       = op;
    r.first_cell      = first_cell;
    r.second_cell     = second_cell;
    r.random_fraction = fraction;
    r.entry_row       = row;
    r.entry_col       = col;
    r.label_value     = label;
    r.probability     = prob;
    return r;
  endfunction

  // small labels make duplicates and repeat hits likely
  function automatic logic [LABEL_W-1:0] random_label();
    if ($urandom_range(0, 9) < 4) return LABEL_W'($urandom_range(0, 40) - 20);
    return LABEL_W'($urandom);
  endfunction

  // mostly small probabilities so the walk goes deep into a row
  function automatic logic [PROB_W-1:0] random_chance();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return PROB_W'(1 << FRAC_W);
    if (sel == 2) return PROB_W'($urandom_range(0, 1 << FRAC_W));
    return PROB_W'($urandom_range(0, 8192));
  endfunction

  // called at a clock edge; valid stays high from one request to the next except across a random idle gap
  task automatic send_request(req_t r);
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PERCENT);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.operation;
    s_tdata  <= {7'd0, r.probability, r.label_value, r.entry_col, r.entry_row,
                 r.random_fraction, r.second_cell, r.first_cell};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every pending sample, then for any write still in flight
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int   rows_plan [PHASES] = '{16, 1, 16, 1, 0, 16, 31, 17, 0};
    int   cols_plan [PHASES] = '{16, 1, 1, 16, 16, 0, 31, 7, 0};
    int   kind, sel, idx;
    req_t r;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load the whole table so no sample ever reads an unwritten entry
    for (int i = 0; i < MAX_ROWS_DEF; i++)
      send_request(make_item(OP_ROW_LABEL, LABEL_W'($urandom), LABEL_W'($urandom),
                             FRAC_W'($urandom), IDX_W'(i), IDX_W'($urandom),
                             random_label(), random_chance()));
    for (int i = 0; i < MAX_COLS_DEF; i++)
      send_request(make_item(OP_COL_LABEL, LABEL_W'($urandom), LABEL_W'($urandom),
                             FRAC_W'($urandom), IDX_W'($urandom), IDX_W'(i),
                             random_label(), random_chance()));
    for (int i = 0; i < MAX_ROWS_DEF; i++)
      for (int j = 0; j < MAX_COLS_DEF; j++)
        send_request(make_item(OP_PROB, LABEL_W'($urandom), LABEL_W'($urandom),
                               FRAC_W'($urandom), IDX_W'(i), IDX_W'(j),
                               random_label(), random_chance()));

    // directed: field extremes, duplicate row labels, both-positive, miss, full probability
    send_request(make_item(OP_ROW_LABEL, 16'h7FFF, 16'h8000, 16'hFFFF, 4'd0, 4'd15,
                           16'h8000, 17'h1FFFF & 17'h10000));
    send_request(make_item(OP_ROW_LABEL, 16'h0000, 16'hFFFF, 16'h0000, 4'd7, 4'd0,
                           16'h8000, 17'd0));
    send_request(make_item(OP_ROW_LABEL, 16'h8000, 16'h0000, 16'h8000, 4'd15, 4'd7,
                           16'h7FFF, 17'h0FFFF));
    send_request(make_item(OP_COL_LABEL, 16'hFFFF, 16'h7FFF, 16'h1234, 4'd15, 4'd0,
                           16'h7FFF, 17'h10000));
    send_request(make_item(OP_COL_LABEL, 16'h0001, 16'h0001, 16'hFFFF, 4'd0, 4'd15,
                           16'h8000, 17'd1));
    send_request(make_item(OP_PROB, 16'h0000, 16'h0000, 16'h0000, 4'd0, 4'd0,
                           16'hFFFF, 17'h10000));
    send_request(make_item(OP_PROB, 16'h7FFF, 16'h8000, 16'h0001, 4'd7, 4'd0,
                           16'h0000, 17'd0));
    send_request(make_item(OP_PROB, 16'h8000, 16'h7FFF, 16'hFFFE, 4'd15, 4'd15,
                           16'h5555, 17'h0FFFF));
    send_request(make_item(OP_SAMPLE, 16'h8000, 16'h8000, 16'hFFFF, 4'd15, 4'd15,
                           16'hFFFF, 17'h1FFFF & 17'h10000));
    send_request(make_item(OP_SAMPLE, 16'h0000, 16'h7FFF, 16'h0000, 4'd0, 4'd0,
                           16'h0000, 17'd0));
    send_request(make_item(OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h8000, 4'd7, 4'd3,
                           16'h8000, 17'h0FFFF));
    send_request(make_item(OP_SAMPLE, 16'h0001, 16'h0001, 16'h0001, 4'd1, 4'd1,
                           16'h0001, 17'd1));
    send_request(make_item(OP_SAMPLE, 16'hFFFF, 16'h8001, 16'h8000, 4'd2, 4'd9,
                           16'h1234, 17'd12345));
    send_request(make_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF, 4'd10, 4'd5,
                           16'h7FFF, 17'd0));
    send_request(make_item(OP_SAMPLE, 16'h7FFF, 16'h0000, 16'h0000, 4'd5, 4'd10,
                           16'h8000, 17'h10000));
    send_request(make_item(OP_SAMPLE, 16'h0000, 16'h8000, 16'h0000, 4'd3, 4'd12,
                           16'hAAAA, 17'h0AAAA));

    for (int p = 0; p < PHASES; p++) begin
      // the first phase keeps the register values left by reset
      if (p > 0) begin
        settle();
        if (p == PHASES - 1) begin
          rows_plan[p] = $urandom_range(0, (1 << REG_W) - 1);
          cols_plan[p] = $urandom_range(0, (1 << REG_W) - 1);
        end
        write_register(REG_ROWS_IN_USE, REG_W'(rows_plan[p]));
        write_register(REG_COLS_IN_USE, REG_W'(cols_plan[p]));
        // an index past the register list must leave everything alone
        idx = (p == 1) ? (1 << CFG_INDEX_W) - 1
                       : $urandom_range(REG_COLS_IN_USE + 1, (1 << CFG_INDEX_W) - 1);
        write_register(CFG_INDEX_W'(idx), REG_W'($urandom));
      end
      steady <= (p == 2);

      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        r = make_item(OP_SAMPLE, LABEL_W'($urandom), LABEL_W'($urandom), FRAC_W'($urandom),
                      IDX_W'($urandom), IDX_W'($urandom), random_label(), random_chance());
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
          r.operation = op_t'($urandom_range(OP_ROW_LABEL, OP_PROB));
        end else if (kind < 35) begin
          r.first_cell  = LABEL_W'($urandom_range(1, 32767));
          r.second_cell = LABEL_W'($urandom_range(1, 32767));
        end else begin
          // mostly a known row label, often one of the first rows
          if (kind < 85) begin
            idx = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                       : $urandom_range(0, MAX_ROWS_DEF - 1);
            r.second_cell = tracker.row_label[idx];
          end
          sel = $urandom_range(0, 3);
          if (sel == 0) r.first_cell = '0;
          else if (sel < 3) r.first_cell[LABEL_W-1] = 1'b1;
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) r.random_fraction = '0;
        else if (sel == 1) r.random_fraction = '1;
        send_request(r);
      end
    end

    settle();
    if (tracker.pending_samples.size() != 0)
      tracker.flag($sformatf("%0d results never arrived", tracker.pending_samples.size()));

    $display("covered %0d table writes and %0d samples: %0d kept, %0d drawn, %0d row misses",
             tracker.table_writes,
             tracker.outcome_count[0] + tracker.outcome_count[1] + tracker.outcome_count[2],
             tracker.outcome_count[ST_UNCHANGED], tracker.outcome_count[ST_SAMPLED],
             tracker.outcome_count[ST_NOT_FOUND]);
    $display("%0d register settings, zero and out-of-range counts included, %0d mismatches",
             PHASES, tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
